FILE: rtl/integer_set_table_defines.svh
// assertion macros used by ist_engine
`ifndef INTEGER_SET_TABLE_DEFINES_SVH
`define INTEGER_SET_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define IST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define IST_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IST_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define IST_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/ist_pkg.sv
package ist_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);
  localparam int COUNT_BITS = 7;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic                  success;
    logic                  was_present;
    logic [COUNT_BITS-1:0] count;
  } out_item_t;

endpackage

FILE: rtl/ist_engine.sv
`include "integer_set_table_defines.svh"

module ist_engine import ist_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  req,
  output logic      idle,
  input  logic      res_free,
  output logic      res_valid,
  output out_item_t res
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]            state;
  logic [1:0]            op_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CNT_BITS-1:0]   occupied;
  logic [CNT_BITS-1:0]   occupied_next;
  logic [CNT_BITS-1:0]   issue_idx;
  logic                  rd_valid;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic                  found;

  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rd_data;

  logic                  issuing;
  logic                  rd_en;
  logic [ADDR_BITS-1:0]  rd_addr_issue;
  logic                  hit;
  logic                  shift_we;
  logic                  commit;
  logic                  add_store;
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  ok;

  assign issuing       = (state == ST_SCAN) && (issue_idx < occupied);
  assign rd_en         = issuing;
  assign rd_addr_issue = issue_idx[ADDR_BITS-1:0];
  assign hit           = rd_valid && !found && (rd_data == val_q);
  // once the match is behind us, each later entry moves down one place
  assign shift_we      = (state == ST_SCAN) && rd_valid && found && (op_q == OP_REMOVE);
  assign commit        = (state == ST_FINISH) && res_free;
  assign add_store     = (op_q == OP_ADD) && !found && (occupied < CNT_BITS'(CAPACITY));

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = rd_addr - 1'b1;
    wr_data = rd_data;
    if (shift_we) begin
      mem_we = 1'b1;
    end else if (commit && add_store) begin
      mem_we  = 1'b1;
      wr_addr = occupied[ADDR_BITS-1:0];
      wr_data = val_q;
    end
  end

  always_comb begin
    occupied_next = occupied;
    ok            = 1'b0;
    unique case (op_q)
      OP_ADD: begin
        ok = found || add_store;
        if (add_store) occupied_next = occupied + 1'b1;
      end
      OP_REMOVE: begin
        ok = found;
        if (found) occupied_next = occupied - 1'b1;
      end
      OP_TEST: ok = found;
      default: ok = 1'b0;
    endcase
  end

  assign idle            = (state == ST_IDLE);
  assign res_valid       = (state == ST_FINISH);
  assign res.success     = ok;
  assign res.was_present = found;
  assign res.count       = COUNT_BITS'(occupied_next);

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr_issue];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_q  <= req.op;
      val_q <= VALUE_BITS'(req.value);
    end
    if (issuing) rd_addr <= rd_addr_issue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occupied  <= '0;
      issue_idx <= '0;
      rd_valid  <= 1'b0;
      found     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            issue_idx <= '0;
            rd_valid  <= 1'b0;
            found     <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issuing) issue_idx <= issue_idx + 1'b1;
          rd_valid <= issuing;
          if (hit) found <= 1'b1;
          if (!issuing && !rd_valid) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (res_free) begin
            occupied <= occupied_next;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `IST_ASSERT_IMP(a_occ_bound, clk, rst, 1'b1, occupied <= CNT_BITS'(CAPACITY), "count above capacity")
  `IST_ASSERT_IMP(a_no_rw_clash, clk, rst, mem_we && rd_en, wr_addr != rd_addr_issue, "read and write hit one entry")
  `IST_ASSERT_IMP(a_shift_above_base, clk, rst, shift_we, rd_addr != '0, "shift from entry zero")
  `IST_ASSERT_NXT(a_occ_hold, clk, rst, !commit, $stable(occupied), "count moved without a commit")
  `IST_ASSERT_NXT(a_remove_dec, clk, rst, commit && op_q == OP_REMOVE && found, occupied == CNT_BITS'($past(occupied) - 1'b1), "remove did not drop count")

endmodule

FILE: rtl/integer_set_table.sv
// channel | dir | payload    | transaction when
// in      | in  | in_item_t  | in_valid && in_ready
// out     | out | out_item_t | out_valid && out_ready
//
// from transaction to result: one read per held entry on the single memory read port,
// then the registered read data, end of scan, and the commit, which waits for res_free
// in_ready is high only while the scan engine is idle; one item at a time
// a finished result sits in the output register, so the next item can enter
// while it waits; the engine holds its commit until that register is free
// rst is synchronous and empties the set; entry memory is not cleared

module integer_set_table import ist_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      start;
  logic      idle;
  logic      res_free;
  logic      res_valid;
  out_item_t res;

  assign in_ready = idle;
  assign start    = in_valid && idle;
  assign res_free = !out_valid || out_ready;

  ist_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (in_item),
    .idle      (idle),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_free) out_item <= res;
  end

endmodule

FILE: tb/tb_integer_set_table.sv
`timescale 1ns / 100ps

module tb_integer_set_table;
  import ist_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         MAX_WAIT  = 14;
  localparam int         POOL_SIZE = 96;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // shadow copy of the set, updated when a request transaction is accepted
  logic [VALUE_BITS-1:0] held_values [CAPACITY];
  int                    held_count = 0;

  out_item_t expected_results [$];
  logic [31:0] value_pool [POOL_SIZE];

  bit burst_mode = 1'b0;
  int mismatches = 0;
  int results_checked = 0;
  int requests_sent = 0;
  int full_rejects = 0;
  int op_seen [4] = '{0, 0, 0, 0};

  integer_set_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #2 clk = ~clk;

  function automatic int pick_wait();
    return burst_mode ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  function automatic out_item_t predict_set_op(in_item_t req);
    out_item_t             res;
    logic [63:0]           wide;
    logic [VALUE_BITS-1:0] key;
    int                    pos;
    wide = {{32{req.value[31]}}, req.value};
    key  = wide[VALUE_BITS-1:0];
    pos  = -1;
    for (int i = 0; i < held_count; i++)
      if (pos < 0 && held_values[i] == key) pos = i;
    res.success     = 1'b0;
    res.was_present = (pos >= 0);
    case (req.op)
      OP_ADD: begin
        if (pos >= 0) begin
          res.success = 1'b1;
        end else if (held_count < CAPACITY) begin
          held_values[held_count] = key;
          held_count++;
          res.success = 1'b1;
        end else begin
          full_rejects++;
        end
      end
      OP_REMOVE: begin
        if (pos >= 0) begin
          for (int i = pos; i + 1 < held_count; i++) held_values[i] = held_values[i+1];
          held_count--;
          res.success = 1'b1;
        end
      end
      OP_TEST: res.success = (pos >= 0);
      default: res.success = 1'b0;
    endcase
    res.count = COUNT_BITS'(held_count);
    return res;
  endfunction

  function automatic bit predict_is_held(input logic [31:0] val);
    for (int i = 0; i < held_count; i++)
      if (held_values[i] == val[VALUE_BITS-1:0]) return 1'b1;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    if (mismatches < 40)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing pending (count)", -1, int'(got.count));
    end else begin
      want = expected_results.pop_front();
      if (got.success !== want.success)
        report_mismatch("success", int'(want.success), int'(got.success));
      if (got.was_present !== want.was_present)
        report_mismatch("was_present", int'(want.was_present), int'(got.was_present));
      if (got.count !== want.count)
        report_mismatch("count", int'(want.count), int'(got.count));
    end
    results_checked++;
  endtask

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_request(input logic [1:0] op, input logic [31:0] val);
    in_item_t req;
    int       gap;
    req.op    = op;
    req.value = val;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    expected_results.push_back(predict_set_op(req));
    requests_sent++;
    op_seen[op]++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [1:0] choose_op(input int add_w, input int remove_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < add_w) return OP_ADD;
    if (r < add_w + remove_w) return OP_REMOVE;
    if (r < 97) return OP_TEST;
    return OP_UNUSED;
  endfunction

  // mostly values that are held or likely to collide, sometimes fresh ones
  function automatic logic [31:0] choose_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && held_count > 0)
      return 32'(held_values[$urandom_range(0, held_count - 1)]);
    if (r < 90) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic test_directed_basic();
    send_request(OP_TEST,   32'd0);
    send_request(OP_REMOVE, 32'd5);
    send_request(OP_UNUSED, 32'd7);
    send_request(OP_ADD,    32'h8000_0000);
    send_request(OP_ADD,    32'h7fff_ffff);
    send_request(OP_ADD,    32'd0);
    send_request(OP_ADD,    32'hffff_ffff);
    send_request(OP_ADD,    32'd1);
    send_request(OP_ADD,    32'h7fff_ffff);
    send_request(OP_TEST,   32'h8000_0000);
    send_request(OP_TEST,   32'hffff_ffff);
    send_request(OP_TEST,   32'd2);
    send_request(OP_UNUSED, 32'd0);
    send_request(OP_UNUSED, 32'd2);
    // middle removal shifts the later entries down
    send_request(OP_REMOVE, 32'd0);
    send_request(OP_TEST,   32'hffff_ffff);
    send_request(OP_REMOVE, 32'd0);
    send_request(OP_REMOVE, 32'h8000_0000);
    send_request(OP_REMOVE, 32'd1);
    send_request(OP_ADD,    32'd0);
    send_request(OP_REMOVE, 32'h7fff_ffff);
    send_request(OP_REMOVE, 32'hffff_ffff);
    send_request(OP_REMOVE, 32'd0);
    send_request(OP_TEST,   32'h7fff_ffff);
    send_request(OP_ADD,    32'h5555_aaaa);
  endtask

  task automatic test_full_store();
    logic [31:0] fresh;
    while (held_count < CAPACITY) send_request(OP_ADD, $urandom);
    fresh = $urandom;
    while (predict_is_held(fresh)) fresh = $urandom;
    send_request(OP_ADD, fresh);
    send_request(OP_ADD, 32'(held_values[CAPACITY-1]));
    send_request(OP_ADD, 32'(held_values[0]));
    send_request(OP_TEST, 32'(held_values[CAPACITY-1]));
    send_request(OP_UNUSED, 32'(held_values[10]));
    send_request(OP_REMOVE, 32'(held_values[CAPACITY-1]));
    send_request(OP_ADD, fresh);
    send_request(OP_ADD, ~fresh);
    send_request(OP_REMOVE, 32'(held_values[0]));
    // empty the store in random order
    while (held_count > 0)
      send_request(OP_REMOVE, 32'(held_values[$urandom_range(0, held_count - 1)]));
    send_request(OP_TEST, fresh);
  endtask

  task automatic test_random_mix(input int total);
    int add_w;
    int remove_w;
    for (int phase = 0; phase * 120 < total; phase++) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      if (phase % 2 == 0) begin
        add_w = 55; remove_w = 20;
      end else begin
        add_w = 20; remove_w = 55;
      end
      for (int k = 0; k < 120 && phase * 120 + k < total; k++)
        send_request(choose_op(add_w, remove_w), choose_value());
      if (phase % 4 == 3) wait_drained();
    end
    burst_mode = 1'b0;
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 10; k++) send_request(choose_op(50, 30), choose_value());
    wait_drained();
    repeat (5) send_request(choose_op(40, 40), choose_value());
  endtask

  initial begin : result_monitor
    out_item_t got;
    int        stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = pick_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      got = out_item;
      @(posedge clk);
      check_result(got);
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("integer_set_table test failed");
    $finish;
  end

  initial begin : main_sequence
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_basic();
    test_full_store();
    test_drain_pause();
    test_random_mix(1560);

    wait_drained();
    // allow for a full scan in case a stray result is still on its way
    repeat (CAPACITY + 16) @(posedge clk);

    $display("sent %0d requests (add %0d, remove %0d, test %0d, unused op %0d)",
             requests_sent, op_seen[OP_ADD], op_seen[OP_REMOVE], op_seen[OP_TEST],
             op_seen[OP_UNUSED]);
    $display("checked %0d results, %0d adds rejected by a full store",
             results_checked, full_rejects);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("integer_set_table test passed");
    end else begin
      $display("integer_set_table test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ist_pkg.sv
rtl/ist_engine.sv
rtl/integer_set_table.sv
tb/tb_integer_set_table.sv
